/* design/rkav_pkg.sv */
// Shared types and constants for the rotary knob accelerated value unit.
`default_nettype none

package rkav_pkg;

  // Valid quadrature transition codes, indexed by {prev_a, prev_b, cur_a, cur_b}
  localparam logic [15:0] ValidCode = 16'h6996;

  // History patterns that mark a full detent
  localparam logic [7:0] HistDown = 8'h2b;
  localparam logic [7:0] HistUp   = 8'h17;

  // Speed curve constants
  localparam logic [15:0] SlowLimit = 16'd1380;
  localparam int          SpeedBase = 1500;
  localparam int          SpeedDiv  = 120;

  // Saturation value of the tick counter
  localparam logic [15:0] TicksMax = 16'hffff;

  // Direction codes
  typedef logic signed [1:0] dir_t;
  localparam dir_t DirNone = 2'sb00;
  localparam dir_t DirUp   = 2'sb01;
  localparam dir_t DirDown = 2'sb11;

  // Decoder result handed to the top level
  typedef struct packed {
    logic [3:0] pairs;
    logic [7:0] history;
    dir_t       dir;
  } decode_t;

endpackage

`default_nettype wire

/* design/rkav_decode.sv */
// Quadrature decoder: pin pair shift, valid-transition filter and detent match.
`default_nettype none

module rkav_decode (
  input  wire logic [3:0]      pairs,
  input  wire logic [7:0]      history,
  input  wire logic            pin_a,
  input  wire logic            pin_b,
  output rkav_pkg::decode_t    dec
);

  logic [3:0] pairs_next;

  assign pairs_next = {pairs[1:0], pin_a, pin_b};

  // Only legal Gray-code steps enter the history
  always_comb begin
    dec.pairs   = pairs_next;
    dec.history = history;
    dec.dir     = rkav_pkg::DirNone;
    if (rkav_pkg::ValidCode[pairs_next]) begin
      dec.history = {history[3:0], pairs_next};
      if ({history[3:0], pairs_next} == rkav_pkg::HistDown) begin
        dec.dir = rkav_pkg::DirDown;
      end else if ({history[3:0], pairs_next} == rkav_pkg::HistUp) begin
        dec.dir = rkav_pkg::DirUp;
      end
    end
  end

endmodule

`default_nettype wire

/* design/rkav_level.sv */
// Step size selection (fixed or speed dependent), value update and clamp.
`default_nettype none

module rkav_level (
  input  wire logic signed [15:0] level,
  input  wire logic        [15:0] elapsed,
  input  wire rkav_pkg::dir_t     dir,
  input  wire logic               adaptive_mode,
  input  wire logic        [14:0] step_size,
  input  wire logic signed [15:0] min_value,
  input  wire logic signed [15:0] max_value,
  output logic signed [15:0]      level_next
);

  localparam int QMax = rkav_pkg::SpeedBase / rkav_pkg::SpeedDiv;

  logic        [3:0]  quot;
  logic        [7:0]  speed_step;
  logic        [14:0] step;
  logic signed [17:0] step_ext;
  logic signed [17:0] sum;
  logic signed [17:0] min_ext;
  logic signed [17:0] max_ext;

  // (SpeedBase - elapsed) / SpeedDiv as a count of threshold compares;
  // at least 1 whenever elapsed is within the slow limit
  always_comb begin
    quot = 4'd1;
    for (int k = 2; k <= QMax; k++) begin
      if (elapsed <= 16'(rkav_pkg::SpeedBase - rkav_pkg::SpeedDiv * k)) begin
        quot = quot + 4'd1;
      end
    end
  end

  // Squared quotient, 1 to 144
  assign speed_step = {4'b0000, quot} * {4'b0000, quot};

  always_comb begin
    if (!adaptive_mode) begin
      step = step_size;
    end else if (elapsed > rkav_pkg::SlowLimit) begin
      step = 15'd1;
    end else begin
      step = {7'b0000000, speed_step};
    end
  end

  // Full-width sum, then clamp with the upper bound checked first
  assign step_ext = signed'({3'b000, step});
  assign min_ext  = {{2{min_value[15]}}, min_value};
  assign max_ext  = {{2{max_value[15]}}, max_value};
  assign sum      = {{2{level[15]}}, level} +
                    ((dir == rkav_pkg::DirDown) ? -step_ext : step_ext);

  always_comb begin
    if (sum >= max_ext) begin
      level_next = max_value;
    end else if (sum <= min_ext) begin
      level_next = min_value;
    end else begin
      level_next = sum[15:0];
    end
  end

endmodule

`default_nettype wire

/* design/rotary_knob_accelerated_value_unit.sv */
// A request accepted into the input register moves on to the result register, which drives m_tvalid.
// Throughput: one request per cycle; input register and result register both
// advance whenever the result register is empty or being taken.
// The decode, step select and clamp form one combinational pass between them.
// Reset (rst, synchronous): pin pairs, history, tick count and value go to zero;
// min 0, max 100, step 1, adaptive mode on; both pipeline stages empty.
`default_nettype none

module rotary_knob_accelerated_value_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // sample requests
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] pin_a, [1] pin_b, [2] time_tick
  // results
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata    // [1:0] direction, [2] changed, [18:3] level
);

  localparam logic [1:0] RegMin      = 2'd0;
  localparam logic [1:0] RegMax      = 2'd1;
  localparam logic [1:0] RegStep     = 2'd2;
  localparam logic [1:0] RegAdaptive = 2'd3;

  // configuration
  logic signed [15:0] min_value;
  logic signed [15:0] max_value;
  logic        [14:0] step_size;
  logic               adaptive_mode;

  // input stage
  logic in_valid;
  logic in_a;
  logic in_b;
  logic in_tick;

  // decoder state
  logic        [3:0]  pairs;
  logic        [7:0]  history;
  logic        [15:0] elapsed;
  logic signed [15:0] level;

  // result stage
  logic               out_valid;
  rkav_pkg::dir_t     out_dir;
  logic               out_changed;
  logic signed [15:0] out_level;

  rkav_pkg::decode_t  dec;
  logic signed [15:0] level_next;
  logic               advance;
  logic               detent;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign detent   = (dec.dir != rkav_pkg::DirNone);

  rkav_decode u_decode (
    .pairs   (pairs),
    .history (history),
    .pin_a   (in_a),
    .pin_b   (in_b),
    .dec     (dec)
  );

  rkav_level u_level (
    .level         (level),
    .elapsed       (elapsed),
    .dir           (dec.dir),
    .adaptive_mode (adaptive_mode),
    .step_size     (step_size),
    .min_value     (min_value),
    .max_value     (max_value),
    .level_next    (level_next)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_value     <= 16'sd0;
      max_value     <= 16'sd100;
      step_size     <= 15'd1;
      adaptive_mode <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        RegMin:      min_value     <= signed'(cfg_data);
        RegMax:      max_value     <= signed'(cfg_data);
        RegStep:     step_size     <= cfg_data[14:0];
        RegAdaptive: adaptive_mode <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_a    <= s_tdata[0];
      in_b    <= s_tdata[1];
      in_tick <= s_tdata[2];
    end
  end

  // decoder state, updated once per processed sample
  always_ff @(posedge clk) begin
    if (rst) begin
      pairs   <= 4'd0;
      history <= 8'd0;
      elapsed <= 16'd0;
      level   <= 16'sd0;
    end else if (advance) begin
      pairs   <= dec.pairs;
      history <= dec.history;
      if (detent) begin
        level   <= level_next;
        elapsed <= 16'd0;
      end else if (in_tick && elapsed != rkav_pkg::TicksMax) begin
        elapsed <= elapsed + 16'd1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_dir     <= dec.dir;
      out_changed <= detent;
      out_level   <= detent ? level_next : level;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b00000, out_level, out_changed, out_dir};

  // changed flag agrees with the reported direction
  a_changed_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_changed == (out_dir != rkav_pkg::DirNone)))
    else $error("changed flag disagrees with direction");

  // a detent with sane bounds lands inside them
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    (advance && detent && (min_value <= max_value)) |=>
      (out_level >= $past(min_value) && out_level <= $past(max_value)))
    else $error("clamped level out of bounds");

  // tick counter only clears or steps by at most one
  a_elapsed: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (elapsed == 16'd0 ||
              {1'b0, elapsed} <= {1'b0, $past(elapsed)} + 17'd1))
    else $error("tick counter jumped");

  // the counter is cleared after every detent
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (advance && detent) |=> (elapsed == 16'd0))
    else $error("tick counter not cleared on detent");

endmodule

`default_nettype wire

/* test/rotary_knob_accelerated_value_unit_tb.sv */
// Self-checking testbench for the rotary knob accelerated value unit.
`timescale 1ns / 100ps

module rotary_knob_accelerated_value_unit_tb;

  localparam int CycleLimit = 1000000;
  localparam int LongHold   = 300;
  localparam int MaxReports = 40;

  // quadrature decode constants, kept separate from the design package
  localparam logic [15:0] QuadLegal  = 16'b0110_1001_1001_0110;
  localparam logic [7:0]  DetentDown = 8'h2b;
  localparam logic [7:0]  DetentUp   = 8'h17;
  localparam int          SlowTicks  = 1380;
  localparam int          SpeedTop   = 1500;
  localparam int          SpeedSlice = 120;

  typedef enum logic [1:0] {
    RegMinValue     = 2'd0,
    RegMaxValue     = 2'd1,
    RegStepSize     = 2'd2,
    RegAdaptiveMode = 2'd3
  } knob_reg_e;

  typedef struct packed {
    rkav_pkg::dir_t     direction;
    logic               changed;
    logic signed [15:0] level;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [0] pin_a, [1] pin_b, [2] time_tick
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [23:0] m_tdata;          // [1:0] direction, [2] changed, [18:3] level

  rotary_knob_accelerated_value_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // samples waiting to be sent and readings waiting to come back
  logic [7:0] pending_samples[$];
  reading_t   expected_readings[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int knob_pos      = 0;
  int cycle_count   = 0;
  int errors        = 0;
  int samples_sent  = 0;
  int readings_seen = 0;
  int up_detents    = 0;
  int down_detents  = 0;
  int clamp_hits    = 0;

  // knob state as the block should hold it
  logic [3:0]         pair_code_q = 4'd0;
  logic [7:0]         history_q   = 8'd0;
  logic [15:0]        ticks_q     = 16'd0;
  logic signed [15:0] level_q     = 16'sd0;
  logic signed [15:0] lower_q     = 16'sd0;
  logic signed [15:0] upper_q     = 16'sd100;
  logic [14:0]        fixed_step_q = 15'd1;
  logic               adaptive_q  = 1'b1;

  // one sample in, one reading out
  function automatic reading_t turn_knob_model(input logic [7:0] sample);
    reading_t r;
    int       delta_step;
    int       speed;
    int       sum;
    pair_code_q = {pair_code_q[1:0], sample[0], sample[1]};
    r.direction = rkav_pkg::DirNone;
    if (QuadLegal[pair_code_q]) begin
      history_q = {history_q[3:0], pair_code_q};
      if (history_q == DetentDown) r.direction = rkav_pkg::DirDown;
      else if (history_q == DetentUp) r.direction = rkav_pkg::DirUp;
    end
    r.changed = (r.direction != rkav_pkg::DirNone);
    if (r.changed) begin
      if (!adaptive_q) begin
        delta_step = int'(fixed_step_q);
      end else if (int'(ticks_q) > SlowTicks) begin
        delta_step = 1;
      end else begin
        speed = (SpeedTop - int'(ticks_q)) / SpeedSlice;
        delta_step = speed * speed;
      end
      if (r.direction == rkav_pkg::DirUp) begin
        sum = int'(level_q) + delta_step;
        up_detents++;
      end else begin
        sum = int'(level_q) - delta_step;
        down_detents++;
      end
      // upper bound wins when the bounds cross
      if (sum >= int'(upper_q)) begin
        sum = int'(upper_q);
        clamp_hits++;
      end else if (sum <= int'(lower_q)) begin
        sum = int'(lower_q);
        clamp_hits++;
      end
      level_q = sum[15:0];
      ticks_q = 16'd0;
    end else if (sample[2] && ticks_q != 16'hffff) begin
      ticks_q = ticks_q + 16'd1;
    end
    r.level = level_q;
    return r;
  endfunction

  // sender: queue to s_tdata, prediction on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_readings.push_back(turn_knob_model(s_tdata));
        samples_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_samples.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      if (errors < MaxReports)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // receiver: checks readings, random stalls and a long hold on request
  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        readings_seen++;
        if (expected_readings.size() == 0) begin
          if (errors < MaxReports)
            $display("%0t: unexpected reading, expected none, got %h", $time, m_tdata);
          errors++;
        end else begin
          want = expected_readings.pop_front();
          report_field("direction", $signed(want.direction), $signed(m_tdata[1:0]));
          report_field("changed", want.changed, m_tdata[2]);
          report_field("level", $signed(want.level), $signed(m_tdata[18:3]));
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("rotary_knob_accelerated_value_unit_tb NOT OK");
      $finish;
    end
  end

  // stimulus helpers; knob_pos is the Gray position 0..3 of the pins
  task automatic place(input logic a, input logic b, input logic tick);
    knob_pos = int'({a, a ^ b});
    pending_samples.push_back({5'd0, tick, b, a});
  endtask

  task automatic move_knob(input int delta, input logic tick);
    logic [1:0] pos;
    pos = 2'(knob_pos + delta);
    place(pos[1], pos[1] ^ pos[0], tick);
  endtask

  task automatic turn(input logic up, input int tick_pct);
    repeat (4) move_knob(up ? 1 : 3, $urandom_range(99) < tick_pct);
  endtask

  task automatic dwell(input int n, input logic tick);
    repeat (n) move_knob(0, tick);
  endtask

  task automatic queue_random(input int n);
    int added;
    int pick;
    int density;
    added = 0;
    while (added < n) begin
      pick    = $urandom_range(99);
      density = 50 * $urandom_range(2);
      if (pick < 65) begin
        turn(1'($urandom_range(1)), density);
        added += 4;
      end else if (pick < 78) begin
        // partial move, often reversing
        move_knob($urandom_range(1) ? 1 : 3, 1'($urandom_range(1)));
        added++;
      end else if (pick < 86) begin
        // skipped state
        move_knob(2, 1'($urandom_range(1)));
        added++;
      end else if (pick < 94) begin
        place(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        added++;
      end else begin
        pick = $urandom_range(1, 12);
        dwell(pick, 1'b1);
        added += pick;
      end
    end
  endtask

  task automatic set_reg(input knob_reg_e idx, input logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      RegMinValue:     lower_q = value;
      RegMaxValue:     upper_q = value;
      RegStepSize:     fixed_step_q = value[14:0];
      RegAdaptiveMode: adaptive_q = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // all samples taken, all readings back, pipeline settled
  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_samples.size() != 0 || s_tvalid || expected_readings.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: adaptive, 0..100; still, skips, ticks on detents, clamps
    place(1'b0, 1'b0, 1'b0);
    place(1'b1, 1'b1, 1'b1);
    place(1'b0, 1'b0, 1'b1);
    turn(1'b1, 100);
    turn(1'b0, 100);
    turn(1'b0, 0);
    move_knob(2, 1'b1);
    turn(1'b1, 0);
    turn(1'b1, 100);
    wait_quiet();

    // full range and the speed curve step near sixty ticks
    set_reg(RegMinValue, 16'h8000);
    set_reg(RegMaxValue, 16'h7fff);
    turn(1'b1, 0);
    begin
      int edges[3] = '{0, 60, 61};
      foreach (edges[i]) begin
        dwell(edges[i], 1'b1);
        turn(1'(i % 2), 0);
      end
    end
    wait_quiet();
    // long receiver hold while the sender keeps offering
    hold_requests++;
    queue_random(50);
    wait_quiet();

    // fixed step at its largest, sender idling, with a pause mid-phase
    send_idle_pct = 73;
    set_reg(RegAdaptiveMode, 16'd0);
    set_reg(RegStepSize, 16'h7fff);
    queue_random(30);
    dwell($urandom_range(100), 1'b1);
    turn(1'($urandom_range(1)), 0);
    wait_quiet();
    queue_random(30);
    wait_quiet();

    // zero step with crossed bounds, receiver stalling
    send_idle_pct = 0;
    stall_pct     = 73;
    set_reg(RegStepSize, 16'd0);
    set_reg(RegMinValue, 16'sd50);
    set_reg(RegMaxValue, -16'sd50);
    dwell(3, 1'b1);
    queue_random(50);
    wait_quiet();

    // adaptive again with narrow random bounds, both sides idling
    send_idle_pct = 34;
    stall_pct     = 34;
    set_reg(RegAdaptiveMode, 16'd1);
    set_reg(RegMinValue, 16'($urandom_range(400)) - 16'd400);
    set_reg(RegMaxValue, 16'($urandom_range(400)));
    queue_random(30);
    dwell($urandom_range(100), 1'b1);
    turn(1'($urandom_range(1)), 0);
    queue_random(30);
    wait_quiet();

    // equal bounds, random fixed step
    set_reg(RegAdaptiveMode, 16'd0);
    set_reg(RegStepSize, 16'($urandom_range(32767)));
    begin
      logic [15:0] pinned;
      pinned = 16'($urandom_range(65535));
      set_reg(RegMinValue, pinned);
      set_reg(RegMaxValue, pinned);
    end
    queue_random(30);
    wait_quiet();

    $display("%0d samples sent, %0d readings checked", samples_sent, readings_seen);
    $display("%0d up and %0d down detents, %0d clamped", up_detents, down_detents, clamp_hits);
    if (errors == 0) begin
      $display("rotary_knob_accelerated_value_unit_tb OK");
    end else begin
      $display("rotary_knob_accelerated_value_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
design/rkav_pkg.sv
design/rkav_decode.sv
design/rkav_level.sv
design/rotary_knob_accelerated_value_unit.sv
test/rotary_knob_accelerated_value_unit_tb.sv
